### rtl/core/bsa_pkg.sv
// Shared types and constants for the bitmap slot allocator.
// Used by every module of the block; no dependencies.
package bsa_pkg;

  localparam int MAX_SLOTS_DEF = 256;
  localparam int MAP_WORDS_DEF = 8;
  localparam int WORD_BITS     = 32;
  localparam int BIT_W         = 5;
  localparam int ADDR_W        = 32;
  localparam int SIZE_W        = 16;
  localparam int COUNT_W       = 9;
  localparam int SLOT_OUT_W    = 8;
  localparam int CFG_IDX_W     = 2;
  localparam int QUEUE_DEPTH   = 2;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_CLEAR = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_EXHAUSTED    = 3'd1,
    ST_INVALID_POOL = 3'd2,
    ST_OUT_OF_RANGE = 3'd3,
    ST_MISALIGNED   = 3'd4,
    ST_DOUBLE_FREE  = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    REG_BASE  = 2'd0,
    REG_SIZE  = 2'd1,
    REG_COUNT = 2'd2
  } reg_idx_t;

  typedef enum logic [2:0] {
    KIND_NOP,
    KIND_ERROR,
    KIND_ALLOC,
    KIND_FREE,
    KIND_CLEAR
  } kind_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base;
    logic [SIZE_W-1:0] size;
    logic [COUNT_W-1:0] count;
  } cfg_t;

  typedef struct packed {
    kind_t             kind;
    status_t           err;
    logic [ADDR_W-1:0] offset;
  } entry_t;

  typedef struct packed {
    status_t               status;
    logic [ADDR_W-1:0]     obj;
    logic [SLOT_OUT_W-1:0] slot;
  } result_t;

endpackage

### rtl/core/bitmap_slot_allocator_top.sv
// Bitmap slot allocator, top level: config registers, front end, queue, back end.
// The front end takes a new word only once it has pushed the last one into the queue;
// alloc and free are bound by the back end: word scan with a read and a scan state
// per word, 9-step serial divider.
// Reset (rst, synchronous): config to defaults, all slots free at once via
// per-word valid flags, no clearing pass.
module bitmap_slot_allocator_top #(
  parameter int MAX_SLOTS = bsa_pkg::MAX_SLOTS_DEF,
  parameter int MAP_WORDS = bsa_pkg::MAP_WORDS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // cmd[1:0], address[33:2], zero pad
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata    // status[2:0], object_address[34:3], slot_index[42:35]
);

  bsa_pkg::cfg_t    cfg;
  logic             push;
  bsa_pkg::entry_t  push_entry;
  logic             full;
  logic             pop_valid;
  logic             pop_ready;
  bsa_pkg::entry_t  pop_entry;
  bsa_pkg::result_t res;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.base  <= '0;
      cfg.size  <= bsa_pkg::SIZE_W'(1);
      cfg.count <= bsa_pkg::COUNT_W'(256);
    end else if (cfg_we) begin
      unique case (bsa_pkg::reg_idx_t'(cfg_index))
        bsa_pkg::REG_BASE:  cfg.base  <= cfg_data;
        bsa_pkg::REG_SIZE:  cfg.size  <= cfg_data[bsa_pkg::SIZE_W-1:0];
        bsa_pkg::REG_COUNT: cfg.count <= cfg_data[bsa_pkg::COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  bsa_front #(
    .MAX_SLOTS(MAX_SLOTS),
    .MAP_WORDS(MAP_WORDS)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_cmd    (s_tdata[1:0]),
    .in_addr   (s_tdata[33:2]),
    .push      (push),
    .push_entry(push_entry),
    .full      (full)
  );

  bsa_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_entry(push_entry),
    .full      (full),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry)
  );

  bsa_back #(
    .MAP_WORDS(MAP_WORDS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .pop_valid(pop_valid),
    .pop_ready(pop_ready),
    .pop_entry(pop_entry),
    .res_valid(m_tvalid),
    .res_ready(m_tready),
    .res      (res)
  );

  assign m_tdata = {5'b0, res.slot, res.obj, res.status};

  a_fail_no_addr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[2:0] != bsa_pkg::ST_OK) |-> (m_tdata[42:3] == '0))
    else $error("failed command carries an address or slot");

  a_front_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("front end took a word while classifying the last one");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result pending after reset");

endmodule

### rtl/core/bsa_front.sv
// Front end: accepts command words, checks the pool and the free address range.
// Pushes classified entries into the queue. Depends on bsa_pkg.
module bsa_front #(
  parameter int MAX_SLOTS = bsa_pkg::MAX_SLOTS_DEF,
  parameter int MAP_WORDS = bsa_pkg::MAP_WORDS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  bsa_pkg::cfg_t             cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [1:0]                in_cmd,
  input  logic [bsa_pkg::ADDR_W-1:0] in_addr,
  output logic                      push,
  output bsa_pkg::entry_t           push_entry,
  input  logic                      full
);

  localparam int MAP_SLOTS = MAP_WORDS * bsa_pkg::WORD_BITS;
  localparam int LIMIT     = (MAX_SLOTS < MAP_SLOTS) ? MAX_SLOTS : MAP_SLOTS;
  localparam int PROD_W    = bsa_pkg::SIZE_W + bsa_pkg::COUNT_W;

  typedef enum logic [1:0] {S_IDLE, S_MUL, S_CHK} state_t;

  state_t                     state;
  logic [1:0]                 cmd;
  logic [bsa_pkg::ADDR_W-1:0] addr;
  logic [PROD_W-1:0]          prod;
  logic [bsa_pkg::ADDR_W:0]   end_addr;
  logic                       pool_ok;
  logic                       in_range;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    end_addr = {1'b0, cfg.base} + (bsa_pkg::ADDR_W + 1)'(prod);
    pool_ok  = (cfg.size != '0) && (cfg.count != '0) &&
               (32'(cfg.count) <= 32'(LIMIT)) && !end_addr[bsa_pkg::ADDR_W];
    in_range = (addr >= cfg.base) && (addr < end_addr[bsa_pkg::ADDR_W-1:0]);
    push_entry.offset = addr - cfg.base;
    push_entry.err    = bsa_pkg::ST_OK;
    push_entry.kind   = bsa_pkg::KIND_NOP;
    if (bsa_pkg::cmd_t'(cmd) == bsa_pkg::CMD_NOP) begin
      push_entry.kind = bsa_pkg::KIND_NOP;
    end else if (!pool_ok) begin
      push_entry.kind = bsa_pkg::KIND_ERROR;
      push_entry.err  = bsa_pkg::ST_INVALID_POOL;
    end else begin
      unique case (bsa_pkg::cmd_t'(cmd))
        bsa_pkg::CMD_ALLOC: push_entry.kind = bsa_pkg::KIND_ALLOC;
        bsa_pkg::CMD_FREE: begin
          if (in_range) begin
            push_entry.kind = bsa_pkg::KIND_FREE;
          end else begin
            push_entry.kind = bsa_pkg::KIND_ERROR;
            push_entry.err  = bsa_pkg::ST_OUT_OF_RANGE;
          end
        end
        bsa_pkg::CMD_CLEAR: push_entry.kind = bsa_pkg::KIND_CLEAR;
        default: push_entry.kind = bsa_pkg::KIND_NOP;
      endcase
    end
    push = (state == S_CHK) && !full;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd   <= in_cmd;
            addr  <= in_addr;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          prod  <= PROD_W'(cfg.size) * PROD_W'(cfg.count);
          state <= S_CHK;
        end
        S_CHK: begin
          if (!full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/bsa_queue.sv
// Short FIFO of classified entries between front and back end.
// Depends on bsa_pkg.
module bsa_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  bsa_pkg::entry_t push_entry,
  output logic            full,
  output logic            pop_valid,
  input  logic            pop_ready,
  output bsa_pkg::entry_t pop_entry
);

  localparam int DEPTH = bsa_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNTW  = $clog2(DEPTH + 1);

  bsa_pkg::entry_t slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CNTW-1:0] fill;
  logic            pop;

  assign full      = (fill == CNTW'(DEPTH));
  assign pop_valid = (fill != '0);
  assign pop_entry = slots[rd_ptr];
  assign pop       = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      fill <= fill + CNTW'(push) - CNTW'(pop);
    end
  end

endmodule

### rtl/core/bsa_back.sv
// Back end: bitmap store, word scan for alloc, serial division for free.
// Holds the result register. Depends on bsa_pkg.
module bsa_back #(
  parameter int MAP_WORDS = bsa_pkg::MAP_WORDS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  bsa_pkg::cfg_t    cfg,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  bsa_pkg::entry_t  pop_entry,
  output logic             res_valid,
  input  logic             res_ready,
  output bsa_pkg::result_t res
);

  localparam int WB     = bsa_pkg::WORD_BITS;
  localparam int BW     = bsa_pkg::BIT_W;
  localparam int WW     = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int SW     = $clog2(MAP_WORDS * WB);
  localparam int CW     = ((SW > bsa_pkg::COUNT_W) ? SW : bsa_pkg::COUNT_W) + 1;
  localparam int PRODW  = CW + bsa_pkg::SIZE_W;
  localparam int QW     = bsa_pkg::COUNT_W;
  localparam int DW     = bsa_pkg::SIZE_W + QW - 1;
  localparam int STEP_W = $clog2(QW);
  localparam int AW     = bsa_pkg::ADDR_W;

  typedef enum logic [2:0] {
    S_IDLE, S_DIV, S_DIV_END, S_READ, S_SCAN, S_MUL, S_ADD
  } state_t;

  logic [WB-1:0]     map_mem [MAP_WORDS];
  logic [MAP_WORDS-1:0] map_valid;
  logic [WB-1:0]     rd_data;

  state_t            state;
  logic              is_alloc;
  logic [WW-1:0]     word_idx;
  logic [CW-1:0]     slot_reg;
  logic [PRODW-1:0]  prod;
  logic [AW-1:0]     rem;
  logic [DW-1:0]     divisor;
  logic [QW-1:0]     quo;
  logic [STEP_W-1:0] step;

  logic [CW-1:0]     base_slot;
  logic [CW-1:0]     avail;
  logic [WB-1:0]     word_mask;
  logic [WB-1:0]     eff_word;
  logic [WB-1:0]     free_bits;
  logic [BW-1:0]     found_bit;
  logic              found;
  logic              last_word;
  logic              slot_used;
  logic              wr_en;
  logic [WB-1:0]     wr_data;
  logic              div_ge;
  logic [CW-1:0]     quo_ext;

  assign pop_ready = (state == S_IDLE) && !res_valid;

  always_comb begin
    base_slot = CW'({word_idx, {BW{1'b0}}});
    avail     = CW'(cfg.count) - base_slot;
    word_mask = (avail >= CW'(WB)) ? '1 : ((WB'(1) << avail[BW-1:0]) - WB'(1));
    last_word = (base_slot + CW'(WB)) >= CW'(cfg.count);
    eff_word  = map_valid[word_idx] ? rd_data : '0;
    free_bits = ~eff_word & word_mask;
    found     = |free_bits;
    found_bit = '0;
    for (int b = WB - 1; b >= 0; b--) begin
      if (free_bits[b]) begin
        found_bit = BW'(b);
      end
    end
    slot_used = eff_word[slot_reg[BW-1:0]];
    wr_en     = 1'b0;
    wr_data   = eff_word;
    if (state == S_SCAN) begin
      if (is_alloc) begin
        wr_en   = found;
        wr_data = eff_word | (WB'(1) << found_bit);
      end else begin
        wr_en   = slot_used;
        wr_data = eff_word & ~(WB'(1) << slot_reg[BW-1:0]);
      end
    end
    div_ge  = rem >= AW'(divisor);
    quo_ext = CW'(quo);
  end

  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      rd_data <= map_mem[word_idx];
    end
    if (wr_en) begin
      map_mem[word_idx] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      map_valid <= '0;
    end else begin
      if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      if (wr_en) begin
        map_valid[word_idx] <= 1'b1;
      end
      unique case (state)
        S_IDLE: begin
          if (pop_valid && pop_ready) begin
            // err is ok for every kind but error
            res.status <= pop_entry.err;
            res.obj    <= '0;
            res.slot   <= '0;
            case (pop_entry.kind)
              bsa_pkg::KIND_ALLOC: begin
                is_alloc <= 1'b1;
                word_idx <= '0;
                state    <= S_READ;
              end
              bsa_pkg::KIND_FREE: begin
                is_alloc <= 1'b0;
                rem      <= pop_entry.offset;
                divisor  <= {cfg.size, {(QW - 1){1'b0}}};
                quo      <= '0;
                step     <= '0;
                state    <= S_DIV;
              end
              bsa_pkg::KIND_CLEAR: begin
                map_valid <= '0;
                res_valid <= 1'b1;
              end
              bsa_pkg::KIND_ERROR: begin
                res_valid <= 1'b1;
              end
              default: res_valid <= 1'b1;
            endcase
          end
        end
        S_DIV: begin
          if (div_ge) begin
            rem <= rem - AW'(divisor);
          end
          quo     <= {quo[QW-2:0], div_ge};
          divisor <= divisor >> 1;
          step    <= step + 1'b1;
          if (step == STEP_W'(QW - 1)) begin
            state <= S_DIV_END;
          end
        end
        S_DIV_END: begin
          if (rem != '0) begin
            res.status <= bsa_pkg::ST_MISALIGNED;
            res_valid  <= 1'b1;
            state      <= S_IDLE;
          end else begin
            slot_reg <= quo_ext;
            word_idx <= WW'(quo_ext >> BW);
            state    <= S_READ;
          end
        end
        S_READ: state <= S_SCAN;
        S_SCAN: begin
          if (is_alloc) begin
            if (found) begin
              slot_reg <= CW'({word_idx, found_bit});
              state    <= S_MUL;
            end else if (last_word) begin
              res.status <= bsa_pkg::ST_EXHAUSTED;
              res_valid  <= 1'b1;
              state      <= S_IDLE;
            end else begin
              word_idx <= word_idx + 1'b1;
              state    <= S_READ;
            end
          end else begin
            if (slot_used) begin
              res.slot <= slot_reg[bsa_pkg::SLOT_OUT_W-1:0];
            end else begin
              res.status <= bsa_pkg::ST_DOUBLE_FREE;
            end
            res_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_MUL: begin
          prod  <= PRODW'(slot_reg) * PRODW'(cfg.size);
          state <= S_ADD;
        end
        S_ADD: begin
          res.obj   <= cfg.base + prod[AW-1:0];
          res.slot  <= slot_reg[bsa_pkg::SLOT_OUT_W-1:0];
          res_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
